@@ design/mb2_pkg.sv @@
// Shared types and constants for the boot information tag parser.
package mb2_pkg;

    // Parse phases of the front end.
    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_GAP  = 2'd1;
    localparam logic [1:0] PH_TAG  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Record kinds.
    localparam logic [2:0] KIND_MAP  = 3'd0;
    localparam logic [2:0] KIND_MOD  = 3'd1;
    localparam logic [2:0] KIND_CMD  = 3'd2;
    localparam logic [2:0] KIND_BOOT = 3'd3;
    localparam logic [2:0] KIND_FIN  = 3'd4;

    // Finish codes.
    localparam logic [2:0] FIN_END     = 3'd0;
    localparam logic [2:0] FIN_EXHAUST = 3'd1;
    localparam logic [2:0] FIN_BUFSMALL = 3'd2;
    localparam logic [2:0] FIN_BADTOTAL = 3'd3;
    localparam logic [2:0] FIN_TRUNC   = 3'd4;
    localparam logic [2:0] FIN_SHORT   = 3'd5;
    localparam logic [2:0] FIN_OVERSIZE = 3'd6;
    localparam logic [2:0] FIN_ALIGN   = 3'd7;

    // Tag types that the parser acts on.
    localparam logic [31:0] TAG_END     = 32'd0;
    localparam logic [31:0] TAG_MODULE  = 32'd3;
    localparam logic [31:0] TAG_BOOTDEV = 32'd5;
    localparam logic [31:0] TAG_MMAP    = 32'd6;
    localparam logic [31:0] TAG_RSDP1   = 32'd14;
    localparam logic [31:0] TAG_RSDP2   = 32'd15;

    localparam logic [31:0] TOTAL_LIMIT = 32'd67108864;
    localparam logic [31:0] MIN_ENTRY   = 32'd24;
    localparam logic [31:0] RSDP1_MIN   = 32'd28;
    localparam logic [31:0] RSDP2_MIN   = 32'd44;
    localparam logic [31:0] BOOT_MIN    = 32'd20;
    localparam logic [31:0] BODY_MIN    = 32'd16;

    localparam int QUEUE_DEPTH = 4;

    // Work that one input byte leaves for the back end: an optional data
    // record, then an optional finish record, plus the shared status.
    typedef struct packed {
        logic        has_rec;
        logic [2:0]  kind;
        logic [5:0]  index;
        logic [63:0] val_a;
        logic [63:0] val_b;
        logic [31:0] val_c;
        logic        has_fin;
        logic [2:0]  fin_status;
        logic        warn;
        logic        rsdp_found;
        logic [25:0] rsdp_offset;
        logic [5:0]  map_count;
        logic [4:0]  module_count;
    } pkt_t;

endpackage

@@ design/mb2_front.sv @@
// Front end: walks the byte stream, tracks tags and builds record packets.
module mb2_front #(
    parameter int MAX_MODULES     = 8,
    parameter int CMDLINE_BYTES   = 128,
    parameter int MAX_MAP_ENTRIES = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    input  logic [26:0]    cfg_data,
    input  logic           in_valid,
    input  logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_first,
    output logic           push,
    output mb2_pkg::pkt_t  push_pkt
);

    localparam int CW = $clog2(CMDLINE_BYTES);

    logic [26:0] buf_bytes_reg;
    logic [26:0] off_reg, off_next;
    logic [26:0] total_reg, total_next;
    logic [1:0]  phase_reg, phase_next;
    logic [26:0] tag_start_reg, tag_start_next;
    logic [31:0] tag_type_reg, tag_type_next;
    logic [31:0] tag_len_reg, tag_len_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] stride_reg, stride_next;
    logic [26:0] estart_reg, estart_next;
    logic [31:0] mstart_reg, mstart_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [5:0]  maps_reg, maps_next;
    logic [4:0]  mods_reg, mods_next;
    logic        rsdp_reg, rsdp_next;
    logic [25:0] rsdp_off_reg, rsdp_off_next;
    logic        warn_reg, warn_next;
    logic        cmd_reg, cmd_next;
    logic [63:0] hold_a_reg, hold_a_next;
    logic [63:0] hold_b_reg, hold_b_next;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_bytes_reg <= '0;
        end else if (cfg_valid) begin
            buf_bytes_reg <= cfg_data;
        end
    end

    // Per-byte parse step.
    always_comb begin
        logic [26:0] off_v;
        logic [26:0] rel_v;
        logic [26:0] room_v;
        logic [31:0] w32_v;
        logic [31:0] er_v;
        logic [31:0] aligned_v;
        logic [31:0] nxt_v;
        logic        go_v;
        logic        accept;

        off_next      = off_reg;
        total_next    = total_reg;
        phase_next    = phase_reg;
        tag_start_next = tag_start_reg;
        tag_type_next = tag_type_reg;
        tag_len_next  = tag_len_reg;
        shift_next    = shift_reg;
        stride_next   = stride_reg;
        estart_next   = estart_reg;
        mstart_next   = mstart_reg;
        cnt_next      = cnt_reg;
        maps_next     = maps_reg;
        mods_next     = mods_reg;
        rsdp_next     = rsdp_reg;
        rsdp_off_next = rsdp_off_reg;
        warn_next     = warn_reg;
        cmd_next      = cmd_reg;
        hold_a_next   = hold_a_reg;
        hold_b_next   = hold_b_reg;
        push_pkt      = '0;
        off_v = '0; rel_v = '0; room_v = '0; w32_v = '0; er_v = '0;
        aligned_v = '0; nxt_v = '0; go_v = 1'b0;
        accept = in_valid & in_ready;

        if (accept) begin
            // A first byte restarts the run.
            if (in_first) begin
                off_next = '0; total_next = '0; phase_next = mb2_pkg::PH_HDR;
                tag_start_next = 27'd8; tag_type_next = '0; tag_len_next = '0;
                shift_next = '0; stride_next = '0; estart_next = '0;
                mstart_next = '0; cnt_next = '0; warn_next = 1'b0;
                cmd_next = 1'b0; hold_a_next = '0; hold_b_next = '0;
            end
            if (phase_next != mb2_pkg::PH_DONE) begin
                off_v = off_next;
                off_next = off_v + 27'd1;
                shift_next = {in_byte, shift_next[63:8]};
                w32_v = shift_next[63:32];

                if (phase_next == mb2_pkg::PH_HDR) begin
                    // Total size header.
                    if (off_v == 27'd0 && buf_bytes_reg < 27'd8) begin
                        push_pkt.has_fin = 1'b1;
                        push_pkt.fin_status = mb2_pkg::FIN_BUFSMALL;
                        phase_next = mb2_pkg::PH_DONE;
                    end else if (off_v == 27'd3) begin
                        if (w32_v < 32'd8 || w32_v > mb2_pkg::TOTAL_LIMIT) begin
                            push_pkt.has_fin = 1'b1;
                            push_pkt.fin_status = mb2_pkg::FIN_BADTOTAL;
                            phase_next = mb2_pkg::PH_DONE;
                        end else begin
                            total_next = (w32_v > {5'd0, buf_bytes_reg}) ?
                                         buf_bytes_reg : w32_v[26:0];
                            maps_next = '0; mods_next = '0;
                            rsdp_next = 1'b0; rsdp_off_next = '0;
                            if (total_next <= 27'd8) begin
                                push_pkt.has_fin = 1'b1;
                                push_pkt.fin_status = mb2_pkg::FIN_EXHAUST;
                                phase_next = mb2_pkg::PH_DONE;
                            end else begin
                                tag_start_next = 27'd8;
                                phase_next = mb2_pkg::PH_GAP;
                            end
                        end
                    end
                end else begin
                    // Skip padding up to the next tag start.
                    go_v = 1'b1;
                    if (phase_next == mb2_pkg::PH_GAP) begin
                        if (off_v != tag_start_next) begin
                            go_v = 1'b0;
                        end else begin
                            phase_next = mb2_pkg::PH_TAG;
                        end
                    end
                    if (go_v) begin
                        rel_v = off_v - tag_start_next;
                        room_v = total_next - tag_start_next;
                        if (rel_v < 27'd8) begin
                            // Tag header.
                            if (rel_v == 27'd3) begin
                                tag_type_next = w32_v;
                            end else if (rel_v == 27'd7) begin
                                tag_len_next = w32_v;
                                stride_next = '0;
                                cmd_next = 1'b0;
                                if (w32_v < 32'd8) begin
                                    push_pkt.has_fin = 1'b1;
                                    push_pkt.fin_status = mb2_pkg::FIN_SHORT;
                                    phase_next = mb2_pkg::PH_DONE;
                                end else if (w32_v > {5'd0, room_v}) begin
                                    push_pkt.has_fin = 1'b1;
                                    push_pkt.fin_status = mb2_pkg::FIN_OVERSIZE;
                                    phase_next = mb2_pkg::PH_DONE;
                                end else if (tag_type_next == mb2_pkg::TAG_END) begin
                                    push_pkt.has_fin = 1'b1;
                                    push_pkt.fin_status = mb2_pkg::FIN_END;
                                    phase_next = mb2_pkg::PH_DONE;
                                end else if ((tag_type_next == mb2_pkg::TAG_RSDP1 &&
                                              w32_v >= mb2_pkg::RSDP1_MIN && !rsdp_next) ||
                                             (tag_type_next == mb2_pkg::TAG_RSDP2 &&
                                              w32_v >= mb2_pkg::RSDP2_MIN)) begin
                                    rsdp_next = 1'b1;
                                    rsdp_off_next = 26'(tag_start_next + 27'd8);
                                end
                            end
                        end else if (tag_type_next == mb2_pkg::TAG_MMAP &&
                                     tag_len_next >= mb2_pkg::BODY_MIN) begin
                            // Memory map body.
                            if (rel_v == 27'd11) begin
                                stride_next = w32_v;
                            end else if (rel_v == 27'd15) begin
                                if (stride_next < mb2_pkg::MIN_ENTRY ||
                                    stride_next > tag_len_next) begin
                                    warn_next = 1'b1;
                                    stride_next = '0;
                                end else begin
                                    estart_next = tag_start_next + 27'd16;
                                end
                            end else if (rel_v >= 27'd16 && stride_next != '0) begin
                                er_v = {5'd0, off_v} - {5'd0, estart_next};
                                if (er_v == 32'd7) begin
                                    hold_a_next = shift_next;
                                end else if (er_v == 32'd15) begin
                                    hold_b_next = shift_next;
                                end else if (er_v == 32'd19) begin
                                    if (({7'd0, estart_next} + {2'd0, stride_next} <=
                                         {7'd0, tag_start_next} + {2'd0, tag_len_next}) &&
                                        maps_next < 6'(MAX_MAP_ENTRIES)) begin
                                        push_pkt.has_rec = 1'b1;
                                        push_pkt.kind = mb2_pkg::KIND_MAP;
                                        push_pkt.index = maps_next;
                                        push_pkt.val_a = hold_a_next;
                                        push_pkt.val_b = hold_b_next;
                                        push_pkt.val_c = w32_v;
                                        maps_next = maps_next + 6'd1;
                                    end
                                end
                                if (er_v == stride_next - 32'd1) begin
                                    estart_next = estart_next + stride_next[26:0];
                                end
                            end
                        end else if (tag_type_next == mb2_pkg::TAG_MODULE &&
                                     tag_len_next >= mb2_pkg::BODY_MIN) begin
                            // Module body and its command line.
                            if (rel_v == 27'd11) begin
                                mstart_next = w32_v;
                            end else if (rel_v == 27'd15) begin
                                if (w32_v > mstart_next && mods_next < 5'(MAX_MODULES)) begin
                                    push_pkt.has_rec = 1'b1;
                                    push_pkt.kind = mb2_pkg::KIND_MOD;
                                    push_pkt.index = {1'b0, mods_next};
                                    push_pkt.val_a = {32'd0, mstart_next};
                                    push_pkt.val_b = {32'd0, w32_v - mstart_next};
                                    mods_next = mods_next + 5'd1;
                                    cmd_next = 1'b1;
                                    cnt_next = '0;
                                end
                            end else if (rel_v >= 27'd16 && cmd_next) begin
                                if ({1'b0, cnt_next} + 1'b1 < (CW + 1)'(CMDLINE_BYTES) &&
                                    in_byte != 8'd0) begin
                                    cnt_next = cnt_next + 1'b1;
                                    push_pkt.has_rec = 1'b1;
                                    push_pkt.kind = mb2_pkg::KIND_CMD;
                                    push_pkt.index = {1'b0, mods_next - 5'd1};
                                    push_pkt.val_c = {24'd0, in_byte};
                                end else begin
                                    cmd_next = 1'b0;
                                end
                            end
                        end else if (tag_type_next == mb2_pkg::TAG_BOOTDEV &&
                                     tag_len_next >= mb2_pkg::BOOT_MIN) begin
                            // Boot device triple.
                            if (rel_v == 27'd11) begin
                                hold_a_next = {32'd0, w32_v};
                            end else if (rel_v == 27'd15) begin
                                hold_b_next = {32'd0, w32_v};
                            end else if (rel_v == 27'd19) begin
                                push_pkt.has_rec = 1'b1;
                                push_pkt.kind = mb2_pkg::KIND_BOOT;
                                push_pkt.val_a = hold_a_next;
                                push_pkt.val_b = hold_b_next;
                                push_pkt.val_c = w32_v;
                            end
                        end
                        // End of the tag: step to the next aligned start, or finish the run.
                        if (phase_next == mb2_pkg::PH_TAG && rel_v >= 27'd7 &&
                            {5'd0, rel_v} + 32'd1 == tag_len_next) begin
                            aligned_v = (tag_len_next + 32'd7) & ~32'd7;
                            nxt_v = {5'd0, tag_start_next} + aligned_v;
                            if (aligned_v > {5'd0, room_v}) begin
                                push_pkt.has_fin = 1'b1;
                                push_pkt.fin_status = mb2_pkg::FIN_ALIGN;
                                phase_next = mb2_pkg::PH_DONE;
                            end else if (nxt_v >= {5'd0, total_next}) begin
                                push_pkt.has_fin = 1'b1;
                                push_pkt.fin_status = mb2_pkg::FIN_EXHAUST;
                                phase_next = mb2_pkg::PH_DONE;
                            end else if (nxt_v > {5'd0, total_next} - 32'd8) begin
                                push_pkt.has_fin = 1'b1;
                                push_pkt.fin_status = mb2_pkg::FIN_TRUNC;
                                phase_next = mb2_pkg::PH_DONE;
                            end else begin
                                tag_start_next = nxt_v[26:0];
                                phase_next = mb2_pkg::PH_GAP;
                            end
                        end
                    end
                end
            end
        end

        // Status snapshot shared by both records of this byte.
        push_pkt.warn         = warn_next;
        push_pkt.rsdp_found   = rsdp_next;
        push_pkt.rsdp_offset  = rsdp_off_next;
        push_pkt.map_count    = maps_next;
        push_pkt.module_count = mods_next;
        push = push_pkt.has_rec | push_pkt.has_fin;
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg <= '0; total_reg <= '0; phase_reg <= mb2_pkg::PH_HDR;
            tag_start_reg <= 27'd8; tag_type_reg <= '0; tag_len_reg <= '0;
            shift_reg <= '0; stride_reg <= '0; estart_reg <= '0;
            mstart_reg <= '0; cnt_reg <= '0; maps_reg <= '0; mods_reg <= '0;
            rsdp_reg <= 1'b0; rsdp_off_reg <= '0; warn_reg <= 1'b0;
            cmd_reg <= 1'b0; hold_a_reg <= '0; hold_b_reg <= '0;
        end else begin
            off_reg <= off_next; total_reg <= total_next; phase_reg <= phase_next;
            tag_start_reg <= tag_start_next; tag_type_reg <= tag_type_next;
            tag_len_reg <= tag_len_next; shift_reg <= shift_next;
            stride_reg <= stride_next; estart_reg <= estart_next;
            mstart_reg <= mstart_next; cnt_reg <= cnt_next; maps_reg <= maps_next;
            mods_reg <= mods_next; rsdp_reg <= rsdp_next;
            rsdp_off_reg <= rsdp_off_next; warn_reg <= warn_next; cmd_reg <= cmd_next;
            hold_a_reg <= hold_a_next; hold_b_reg <= hold_b_next;
        end
    end

endmodule

@@ design/mb2_fifo.sv @@
// Short packet queue between the parser front end and the output back end.
module mb2_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mb2_pkg::pkt_t  push_pkt,
    input  logic           pop,
    output mb2_pkg::pkt_t  pop_pkt,
    output logic           full,
    output logic           empty
);

    localparam int AW = $clog2(mb2_pkg::QUEUE_DEPTH);

    mb2_pkg::pkt_t mem [mb2_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full    = (count_reg == (AW + 1)'(mb2_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_pkt = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue underflow");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> count_reg == '0) else $error("queue not empty after reset");
`endif

endmodule

@@ design/mb2_back.sv @@
// Back end: turns queued packets into output beats, data record first.
module mb2_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  mb2_pkg::pkt_t  pop_pkt,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [207:0]   m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);

    mb2_pkg::pkt_t cur_reg;
    logic          valid_reg;
    logic          fin_sel_reg;
    logic          last_beat;
    logic          take;

    assign last_beat = fin_sel_reg | ~cur_reg.has_fin;
    assign take      = ~valid_reg | (m_tready & last_beat);
    assign pop       = take & ~empty;

    // Beat control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            fin_sel_reg <= 1'b0;
        end else if (take) begin
            valid_reg   <= ~empty;
            fin_sel_reg <= ~pop_pkt.has_rec;
        end else if (m_tready) begin
            fin_sel_reg <= 1'b1;
        end
    end

    // Packet holding register.
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_pkt;
        end
    end

    // Output beat fields.
    always_comb begin
        m_tvalid = valid_reg;
        m_tlast  = last_beat;
        m_tuser  = fin_sel_reg ? mb2_pkg::KIND_FIN : cur_reg.kind;
        m_tdata  = {cur_reg.module_count, cur_reg.map_count, cur_reg.rsdp_offset,
                    cur_reg.rsdp_found, cur_reg.warn,
                    fin_sel_reg ? cur_reg.fin_status : 3'd0,
                    fin_sel_reg ? 32'd0 : cur_reg.val_c,
                    fin_sel_reg ? 64'd0 : cur_reg.val_b,
                    fin_sel_reg ? 64'd0 : cur_reg.val_a,
                    fin_sel_reg ? 6'd0 : cur_reg.index};
    end

endmodule

@@ design/multiboot2_tag_parser.sv @@
// Top level of the boot information tag parser.
// The parser takes one buffer byte per clock cycle, little endian, unless the
// four-packet queue before the output register is full, so it keeps taking
// bytes while results wait. Each byte yields zero, one or two result beats,
// and two (record, then finish) leave in turn by the single output port, so
// the sustained rate is one byte per cycle when no byte yields two beats
// and the sink is always ready. The cfg port is always ready; the user must
// write buffer_bytes only while no byte is in flight, which the block does
// not enforce. Records leave as one beat each: tlast marks the last beat
// caused by an input byte and tuser carries the record kind.
module multiboot2_tag_parser #(
    parameter int MAX_MODULES     = 8,
    parameter int CMDLINE_BYTES   = 128,
    parameter int MAX_MAP_ENTRIES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write: buffer_bytes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [26:0]  cfg_data,
    // Input beat.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [0:0]   s_tuser,   // first_byte
    // Result beat.
    output logic         m_tvalid,
    input  logic         m_tready,
    // record_index, value_a, value_b, value_c, finish_status, map_size_warning,
    // rsdp_found, rsdp_offset, map_count, module_count
    output logic [207:0] m_tdata,
    output logic [2:0]   m_tuser,   // record_kind
    output logic         m_tlast    // last_of_run
);

    logic          push, pop, full, empty;
    mb2_pkg::pkt_t push_pkt, pop_pkt;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~full;

    mb2_front #(
        .MAX_MODULES     (MAX_MODULES),
        .CMDLINE_BYTES   (CMDLINE_BYTES),
        .MAX_MAP_ENTRIES (MAX_MAP_ENTRIES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_first  (s_tuser[0]),
        .push      (push),
        .push_pkt  (push_pkt)
    );

    mb2_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .pop_pkt  (pop_pkt),
        .full     (full),
        .empty    (empty)
    );

    mb2_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_pkt  (pop_pkt),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ verif/multiboot2_tag_parser_tb.sv @@
// Self-checking testbench for the boot information tag parser.
`timescale 1ns / 1ps

module multiboot2_tag_parser_tb;

    localparam int MAX_MODULES     = 8;
    localparam int CMDLINE_BYTES   = 128;
    localparam int MAX_MAP_ENTRIES = 32;
    localparam int unsigned MASK27 = 32'h7FF_FFFF;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } in_byte_t;

    typedef struct {
        logic [2:0]  kind;
        logic [5:0]  index;
        logic [63:0] val_a;
        logic [63:0] val_b;
        logic [31:0] val_c;
        logic [2:0]  status;
        logic        warn;
        logic        rsdp_found;
        logic [25:0] rsdp_offset;
        logic [5:0]  map_count;
        logic [4:0]  module_count;
        logic        last;
    } record_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [26:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    multiboot2_tag_parser #(
        .MAX_MODULES(MAX_MODULES),
        .CMDLINE_BYTES(CMDLINE_BYTES),
        .MAX_MAP_ENTRIES(MAX_MAP_ENTRIES)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    // Stimulus and expectation stores.
    in_byte_t pending_bytes[$];
    record_t  expected_records[$];
    record_t  step_records[$];
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       rx_hold_cycles = 0;
    int       error_count = 0;
    int       bytes_sent = 0;
    int       kind_seen[8];

    // Parser state mirror.
    int unsigned buf_len_cfg = 0;
    int unsigned byte_pos, total_eff, tag_base, cur_type, cur_len;
    int unsigned stride, ent_base, mod_base, cmd_count;
    int unsigned maps_stored = 0, mods_stored = 0, rsdp_pos = 0;
    logic [1:0]  phase;
    logic [63:0] window, held_a, held_b;
    bit          rsdp_seen = 0, map_warn, cmd_on;

    function automatic void restart_parse();
        byte_pos = 0; total_eff = 0; phase = mb2_pkg::PH_HDR; tag_base = 8;
        cur_type = 0; cur_len = 0; window = '0; stride = 0; ent_base = 0;
        mod_base = 0; cmd_count = 0; map_warn = 0; cmd_on = 0;
        held_a = '0; held_b = '0;
    endfunction

    function automatic void add_record(logic [2:0] kind, int unsigned idx, logic [63:0] a,
                                       logic [63:0] b, logic [31:0] c, logic [2:0] st);
        record_t r;
        if (step_records.size() >= 2) return;
        r.kind = kind; r.index = idx[5:0]; r.val_a = a; r.val_b = b; r.val_c = c;
        r.status = st; r.warn = map_warn; r.rsdp_found = rsdp_seen;
        r.rsdp_offset = rsdp_pos[25:0]; r.map_count = maps_stored[5:0];
        r.module_count = mods_stored[4:0]; r.last = 0;
        step_records.push_back(r);
    endfunction

    function automatic void finish_run(logic [2:0] st);
        add_record(mb2_pkg::KIND_FIN, 0, '0, '0, '0, st);
        phase = mb2_pkg::PH_DONE;
    endfunction

    function automatic void on_tag_header(int unsigned size);
        cur_len = size; stride = 0; cmd_on = 0;
        if (size < 8) begin
            finish_run(mb2_pkg::FIN_SHORT); return;
        end
        if (size > total_eff - tag_base) begin
            finish_run(mb2_pkg::FIN_OVERSIZE); return;
        end
        if (cur_type == mb2_pkg::TAG_END) begin
            finish_run(mb2_pkg::FIN_END); return;
        end
        // A v1 pointer only counts when none is known yet; v2 always wins.
        if (cur_type == mb2_pkg::TAG_RSDP1 && size >= mb2_pkg::RSDP1_MIN && !rsdp_seen) begin
            rsdp_seen = 1; rsdp_pos = tag_base + 8;
        end else if (cur_type == mb2_pkg::TAG_RSDP2 && size >= mb2_pkg::RSDP2_MIN) begin
            rsdp_seen = 1; rsdp_pos = tag_base + 8;
        end
    endfunction

    function automatic void on_tag_body(int unsigned off, int unsigned rel, logic [7:0] b,
                                        int unsigned w32);
        int unsigned er;
        if (cur_type == mb2_pkg::TAG_MMAP && cur_len >= mb2_pkg::BODY_MIN) begin
            if (rel == 11) begin
                stride = w32;
            end else if (rel == 15) begin
                if (stride < mb2_pkg::MIN_ENTRY || stride > cur_len) begin
                    map_warn = 1; stride = 0;
                end else begin
                    ent_base = tag_base + 16;
                end
            end else if (rel >= 16 && stride != 0) begin
                er = off - ent_base;
                if (er == 7) held_a = window;
                else if (er == 15) held_b = window;
                else if (er == 19) begin
                    if (64'(ent_base) + 64'(stride) <= 64'(tag_base) + 64'(cur_len) &&
                        maps_stored < MAX_MAP_ENTRIES) begin
                        maps_stored++;
                        add_record(mb2_pkg::KIND_MAP, maps_stored - 1, held_a, held_b, w32,
                                   mb2_pkg::FIN_END);
                    end
                end
                if (er == stride - 1) ent_base += stride;
            end
        end else if (cur_type == mb2_pkg::TAG_MODULE && cur_len >= mb2_pkg::BODY_MIN) begin
            if (rel == 11) begin
                mod_base = w32;
            end else if (rel == 15) begin
                if (w32 > mod_base && mods_stored < MAX_MODULES) begin
                    mods_stored++;
                    cmd_on = 1; cmd_count = 0;
                    add_record(mb2_pkg::KIND_MOD, mods_stored - 1, 64'(mod_base),
                               64'(w32 - mod_base), '0, mb2_pkg::FIN_END);
                end
            end else if (rel >= 16 && cmd_on) begin
                if (cmd_count + 1 < CMDLINE_BYTES && b != 0) begin
                    cmd_count++;
                    add_record(mb2_pkg::KIND_CMD, mods_stored - 1, '0, '0, 32'(b),
                               mb2_pkg::FIN_END);
                end else begin
                    cmd_on = 0;
                end
            end
        end else if (cur_type == mb2_pkg::TAG_BOOTDEV && cur_len >= mb2_pkg::BOOT_MIN) begin
            if (rel == 11) held_a = 64'(w32);
            else if (rel == 15) held_b = 64'(w32);
            else if (rel == 19) add_record(mb2_pkg::KIND_BOOT, 0, held_a, held_b, w32,
                                           mb2_pkg::FIN_END);
        end
    endfunction

    function automatic void on_tag_end();
        int unsigned aligned, nxt;
        aligned = (cur_len + 7) & ~32'd7;
        if (aligned > total_eff - tag_base) begin
            finish_run(mb2_pkg::FIN_ALIGN); return;
        end
        nxt = tag_base + aligned;
        if (nxt >= total_eff) begin
            finish_run(mb2_pkg::FIN_EXHAUST); return;
        end
        if (nxt > total_eff - 8) begin
            finish_run(mb2_pkg::FIN_TRUNC); return;
        end
        tag_base = nxt;
        phase = mb2_pkg::PH_GAP;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic first);
        int unsigned off, w32, rel;
        if (first) restart_parse();
        if (phase == mb2_pkg::PH_DONE) return;
        off = byte_pos;
        byte_pos = (off + 1) & MASK27;
        window = {b, window[63:8]};
        w32 = window[63:32];
        if (phase == mb2_pkg::PH_HDR) begin
            if (off == 0 && buf_len_cfg < 8) begin
                finish_run(mb2_pkg::FIN_BUFSMALL);
            end else if (off == 3) begin
                if (w32 < 8 || w32 > mb2_pkg::TOTAL_LIMIT) begin
                    finish_run(mb2_pkg::FIN_BADTOTAL);
                end else begin
                    total_eff = (w32 > buf_len_cfg) ? buf_len_cfg : w32;
                    maps_stored = 0; mods_stored = 0; rsdp_seen = 0; rsdp_pos = 0;
                    if (total_eff <= 8) begin
                        finish_run(mb2_pkg::FIN_EXHAUST);
                    end else begin
                        tag_base = 8; phase = mb2_pkg::PH_GAP;
                    end
                end
            end
        end else begin
            // Padding before an aligned tag start is skipped.
            if (phase == mb2_pkg::PH_GAP && off != tag_base) return;
            phase = mb2_pkg::PH_TAG;
            rel = off - tag_base;
            if (rel < 8) begin
                if (rel == 3) cur_type = w32;
                else if (rel == 7) on_tag_header(w32);
            end else begin
                on_tag_body(off, rel, b, w32);
            end
            if (phase == mb2_pkg::PH_TAG && rel >= 7 && rel + 1 == cur_len) on_tag_end();
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic first);
        step_records.delete();
        parse_byte(b, first);
        if (step_records.size() > 0) step_records[step_records.size() - 1].last = 1;
        foreach (step_records[i]) expected_records.push_back(step_records[i]);
    endfunction

    // Input driver: offers pending bytes and mirrors each accepted beat.
    always @(posedge aclk) begin
        in_byte_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tuser[0]);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    it = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data;
                    s_tuser  <= it.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink with random stalls and an occasional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            error_count++;
        end
    endfunction

    // Result monitor: compares every accepted beat with the oldest expectation.
    always @(posedge aclk) begin
        record_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected result beat, kind %0d data %h", $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                e = expected_records.pop_front();
                kind_seen[e.kind]++;
                check_field("record_kind", 64'(e.kind), 64'(m_tuser));
                check_field("record_index", 64'(e.index), 64'(m_tdata[5:0]));
                check_field("value_a", e.val_a, m_tdata[69:6]);
                check_field("value_b", e.val_b, m_tdata[133:70]);
                check_field("value_c", 64'(e.val_c), 64'(m_tdata[165:134]));
                check_field("finish_status", 64'(e.status), 64'(m_tdata[168:166]));
                check_field("map_size_warning", 64'(e.warn), 64'(m_tdata[169]));
                check_field("rsdp_found", 64'(e.rsdp_found), 64'(m_tdata[170]));
                check_field("rsdp_offset", 64'(e.rsdp_offset), 64'(m_tdata[196:171]));
                check_field("map_count", 64'(e.map_count), 64'(m_tdata[202:197]));
                check_field("module_count", 64'(e.module_count), 64'(m_tdata[207:203]));
                check_field("last_of_run", 64'(e.last), 64'(m_tlast));
            end
        end
    end

    // Buffer construction helpers.
    function automatic void put_word(ref logic [7:0] q[$], input int unsigned w);
        for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void put_tag(ref logic [7:0] q[$], input int unsigned ttype,
                                    ref logic [7:0] body[$]);
        put_word(q, ttype);
        put_word(q, body.size() + 8);
        foreach (body[i]) q.push_back(body[i]);
        while (q.size() % 8 != 0) q.push_back(8'($urandom));
    endfunction

    function automatic void queue_buffer(ref logic [7:0] q[$]);
        in_byte_t it;
        foreach (q[i]) begin
            it.data = q[i];
            it.first = (i == 0);
            pending_bytes.push_back(it);
        end
    endfunction

    function automatic void queue_words(input int unsigned w[]);
        logic [7:0] q[$];
        foreach (w[i]) put_word(q, w[i]);
        queue_buffer(q);
    endfunction

    // A well-formed buffer with random tags, sometimes damaged afterwards.
    function automatic void random_buffer(bit damage);
        logic [7:0] q[$];
        logic [7:0] body[$];
        int unsigned ttype, esz, n, s;
        for (int i = 0; i < 8; i++) q.push_back(8'($urandom));
        for (int t = $urandom_range(1, 4); t > 0; t--) begin
            body.delete();
            case ($urandom_range(0, 6))
                0: begin
                    ttype = mb2_pkg::TAG_MMAP;
                    case ($urandom_range(0, 5))
                        0: esz = 32;
                        1: esz = $urandom_range(0, 23);
                        2: esz = $urandom_range(25, 60);
                        default: esz = 24;
                    endcase
                    n = $urandom_range(0, 3);
                    put_word(body, esz);
                    put_word(body, $urandom);
                    for (int k = 0; k < n * (esz < 24 ? 24 : esz); k++)
                        body.push_back(8'($urandom));
                    for (int k = $urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 0; k > 0; k--)
                        body.push_back(8'($urandom));
                end
                1, 2: begin
                    ttype = mb2_pkg::TAG_MODULE;
                    s = $urandom;
                    put_word(body, s);
                    put_word(body, $urandom_range(0, 5) == 0 ? s - $urandom_range(0, 3)
                                                             : s + $urandom_range(1, 65536));
                    for (int k = $urandom_range(0, 12); k > 0; k--)
                        body.push_back(8'($urandom_range(1, 255)));
                    if ($urandom_range(0, 3) != 0) body.push_back(8'h00);
                end
                3: begin
                    ttype = mb2_pkg::TAG_BOOTDEV;
                    for (int k = 0; k < 12; k++) body.push_back(8'($urandom));
                end
                4: begin
                    ttype = $urandom_range(0, 1) ? mb2_pkg::TAG_RSDP1 : mb2_pkg::TAG_RSDP2;
                    for (int k = $urandom_range(16, 40); k > 0; k--)
                        body.push_back(8'($urandom));
                end
                default: begin
                    ttype = $urandom_range(7, 13);
                    for (int k = $urandom_range(0, 12); k > 0; k--)
                        body.push_back(8'($urandom));
                end
            endcase
            put_tag(q, ttype, body);
        end
        if ($urandom_range(0, 7) != 0) begin
            body.delete();
            put_tag(q, mb2_pkg::TAG_END, body);
        end
        s = q.size();
        if ($urandom_range(0, 9) == 0) s = s + 8 * $urandom_range(1, 3);
        for (int i = 0; i < 4; i++) q[i] = s[8*i +: 8];
        if (damage) begin
            case ($urandom_range(0, 2))
                0: q[$urandom_range(8, q.size() - 1)] = 8'($urandom);
                1: q = q[0 : $urandom_range(2, q.size() - 1)];
                default: q[$urandom_range(0, 3)] = 8'($urandom);
            endcase
        end
        // Trailing bytes after a finished run are ignored by the parser.
        if ($urandom_range(0, 5) == 0) q.push_back(8'($urandom));
        queue_buffer(q);
    endfunction

    // Crowded buffer: more modules than the limit and an overlong command line.
    function automatic void crowded_buffer();
        logic [7:0] q[$];
        logic [7:0] body[$];
        put_word(q, 0);
        put_word(q, 0);
        put_word(body, mb2_pkg::MIN_ENTRY);
        put_word(body, 0);
        for (int k = 0; k < 2 * 24; k++) body.push_back(8'($urandom));
        put_tag(q, mb2_pkg::TAG_MMAP, body);
        for (int m = 0; m < 9; m++) begin
            body.delete();
            put_word(body, 32'h1000 * m);
            put_word(body, 32'h1000 * m + 32'hFFF);
            for (int k = (m == 0) ? 140 : 2; k > 0; k--) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'h00);
            put_tag(q, mb2_pkg::TAG_MODULE, body);
        end
        body.delete();
        put_tag(q, mb2_pkg::TAG_END, body);
        for (int i = 0; i < 4; i++) q[i] = 8'(q.size() >> (8 * i));
        queue_buffer(q);
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_records.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_buffer_len(int unsigned v);
        cfg_valid <= 1'b1;
        cfg_data  <= v[26:0];
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        buf_len_cfg = v & MASK27;
    endtask

    initial begin
        int unsigned len_choice[4] = '{4096, 64, 32'h400_0000, 4096};
        int tx_pct[4] = '{0, 60, 0, 22};
        int rx_pct[4] = '{0, 0, 60, 22};
        int goal;
        restart_parse();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // With the reset length of zero the buffer is too small at once.
        pending_bytes.push_back('{8'h55, 1'b0});
        pending_bytes.push_back('{8'hAA, 1'b0});
        wait_idle();
        write_buffer_len(7);
        queue_words('{16, 0});
        wait_idle();
        write_buffer_len(4096);
        queue_words('{7, 0});                     // total below eight
        queue_words('{32'h400_0001, 0});           // total above the limit
        queue_words('{8, 0});                     // nothing after the header
        queue_words('{24, 0, 1, 4, 0, 0});         // short tag
        queue_words('{24, 0, 1, 100, 0, 0});       // oversize tag
        queue_words('{20, 0, 1, 9, 0});            // padded tag runs past the end
        queue_words('{20, 0, 1, 8, 0});            // no room for the next header
        queue_words('{48, 0, mb2_pkg::TAG_BOOTDEV, 20, 32'hFFFF_FFFF, 0, 32'h8000_0001, 0,
                      mb2_pkg::TAG_END, 8});
        queue_words('{96, 0, mb2_pkg::TAG_RSDP1, 28, 1, 2, 3, 4, 5, 0, mb2_pkg::TAG_RSDP2, 44,
                      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, mb2_pkg::TAG_END, 8});
        queue_words('{64, 0, mb2_pkg::TAG_MODULE, 40, 5});  // cut short, then restarted
        crowded_buffer();
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            write_buffer_len(len_choice[p]);
            tx_idle_pct = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            if (p == 0) rx_hold_cycles = 400;
            goal = bytes_sent + pending_bytes.size() + 110;
            while (bytes_sent + pending_bytes.size() < goal) begin
                random_buffer($urandom_range(0, 6) == 0);
                if (p == 3 && pending_bytes.size() > 60) begin
                    // Let the parser drain completely before going on.
                    wait_idle();
                end
            end
            wait_idle();
        end
        write_buffer_len(0);
        queue_words('{16, 0});
        wait_idle();

        $display("Sent %0d bytes: %0d map, %0d module, %0d command-line, %0d boot-device,",
                 bytes_sent, kind_seen[mb2_pkg::KIND_MAP], kind_seen[mb2_pkg::KIND_MOD],
                 kind_seen[mb2_pkg::KIND_CMD], kind_seen[mb2_pkg::KIND_BOOT]);
        $display("and %0d finish records checked under four handshake pressure mixes.",
                 kind_seen[mb2_pkg::KIND_FIN]);
        if (error_count == 0 && expected_records.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
